// ===== sv/fre_pkg.sv =====
`default_nettype none

package fre_pkg;

    // register file
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_SIZE_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_SIZE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_FRAMES = 2'd3;

    localparam logic [15:0]           NOISE_RST = 16'd0;
    localparam logic [CFG_SIZE_W-1:0] FRAME_RST = 13'd1024;
    localparam logic [CFG_SIZE_W-1:0] HOP_RST   = 13'd512;
    localparam logic                  EMIT_RST  = 1'b1;

    typedef struct packed {
        logic [15:0]           gate_lvl;
        logic [CFG_SIZE_W-1:0] frm_len;
        logic [CFG_SIZE_W-1:0] hop_len;
        logic                  emit_frames;
    } t_cfg;

    // result item
    localparam int RES_W = 48;
    localparam int CNT_W = 32;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_VAR   = 1'b1;

    // job handed from front to back
    localparam int JOB_SUM_W = 64;
    typedef struct packed {
        logic                  has_frame;
        logic                  is_end;
        logic [JOB_SUM_W-1:0]  sum;
        logic [CFG_SIZE_W-1:0] len;
    } t_job;

    localparam int JOB_Q_DEPTH = 4;
    localparam int JOB_Q_AW    = 2;

    // shared divider
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = 7;

    // stats
    localparam int MEAN_W = 32;
    localparam int ACC_W  = 64;
    localparam int RMS_W  = 24;
    localparam logic [31:0] RMS_MAX = 32'h00FF_FFFF;
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = 5;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_Q_GO,
        BK_Q_WAIT,
        BK_SQ_GO,
        BK_SQ_RUN,
        BK_W_GO,
        BK_W_WAIT,
        BK_MUL,
        BK_ACC,
        BK_EMIT_F,
        BK_V_GO,
        BK_V_WAIT,
        BK_EMIT_V
    } t_back_st;

endpackage

`default_nettype wire

// ===== sv/fre_if.sv =====
`default_nettype none

interface fre_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clip_end;

    modport source (output valid, sample, clip_end, input ready);
    modport sink   (input valid, sample, clip_end, output ready);
endinterface

interface fre_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [47:0] result_value;
    logic [31:0] frame_count;
    logic        end_of_run;

    modport source (output valid, kind, result_value, frame_count, end_of_run, input ready);
    modport sink   (input valid, kind, result_value, frame_count, end_of_run, output ready);
endinterface

`default_nettype wire

// ===== sv/fre_fifo.sv =====
`default_nettype none

module fre_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  fre_pkg::t_job      i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output fre_pkg::t_job      o_data,
    output logic               o_empty
);
    import fre_pkg::*;

    t_job                r_mem [JOB_Q_DEPTH];
    logic [JOB_Q_AW-1:0] r_wp;
    logic [JOB_Q_AW-1:0] r_rp;
    logic [JOB_Q_AW:0]   r_cnt;
    logic                w_wr;
    logic                w_rd;

    assign o_full  = (r_cnt == (JOB_Q_AW+1)'(JOB_Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/fre_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module fre_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [fre_pkg::DIV_NUM_W-1:0]    i_num,
    input  wire logic [fre_pkg::DIV_DEN_W-1:0]    i_den,
    output logic                                  o_done,
    output logic [fre_pkg::DIV_NUM_W-1:0]         o_quo
);
    import fre_pkg::*;

    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   w_trial;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIV_DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/fre_front.sv =====
`default_nettype none

// Squares samples into the open frame lanes and queues a job per close / clip end.
module fre_front #(
    parameter int OPEN_FRAMES = 8,
    parameter int MAX_FRAME   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    fre_in_if.sink         i_in,
    input  fre_pkg::t_cfg  i_cfg,
    input  wire logic      i_full,
    output logic           o_push,
    output fre_pkg::t_job  o_job
);
    import fre_pkg::*;

    localparam int SLOT_W = (OPEN_FRAMES > 1) ? $clog2(OPEN_FRAMES) : 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = SQ_W + CFG_SIZE_W;
    localparam int CAP_W  = CFG_SIZE_W + SLOT_W + 1;
    localparam logic [CFG_SIZE_W-1:0] MAXF =
        (MAX_FRAME > 8191) ? {CFG_SIZE_W{1'b1}} : CFG_SIZE_W'(MAX_FRAME);

    logic [SUM_W-1:0]      r_sum  [OPEN_FRAMES];
    logic [CFG_SIZE_W-1:0] r_len  [OPEN_FRAMES];
    logic [OPEN_FRAMES-1:0] r_open;
    logic [SLOT_W-1:0]     r_oldest;
    logic [SLOT_W-1:0]     r_next;
    logic [CFG_SIZE_W-1:0] r_phase;

    logic [SUM_W-1:0]      n_sum  [OPEN_FRAMES];
    logic [CFG_SIZE_W-1:0] n_len  [OPEN_FRAMES];
    logic [OPEN_FRAMES-1:0] n_open;
    logic [SLOT_W-1:0]     n_next;
    logic [CFG_SIZE_W-1:0] n_phase;

    logic [CFG_SIZE_W-1:0]  w_hop;
    logic [CFG_SIZE_W-1:0]  w_frm;
    logic [CAP_W-1:0]       w_cap;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [SQ_W-1:0]        w_sq;
    logic [2*SAMPLE_BITS-1:0] w_sq_full;
    logic                   w_acc;
    logic                   w_close;
    logic [CFG_SIZE_W:0]    w_ph1;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (32'(s) == OPEN_FRAMES - 1) ? '0 : SLOT_W'(s + 1'b1);
    endfunction

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;

    // effective sizes
    always_comb begin
        w_hop = (i_cfg.hop_len == '0) ? CFG_SIZE_W'(1) : i_cfg.hop_len;
        if (w_hop > MAXF) begin
            w_hop = MAXF;
        end
        w_cap = CAP_W'(w_hop) * CAP_W'(OPEN_FRAMES);
        w_frm = (i_cfg.frm_len == '0) ? CFG_SIZE_W'(1) : i_cfg.frm_len;
        if (w_frm > MAXF) begin
            w_frm = MAXF;
        end
        if (CAP_W'(w_frm) > w_cap) begin
            w_frm = w_cap[CFG_SIZE_W-1:0];
        end
    end

    // squared magnitude with noise gate
    always_comb begin
        w_mag = i_in.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~i_in.sample + 1'b1)
                                           : SAMPLE_BITS'(i_in.sample);
        if (32'(w_mag) < 32'(i_cfg.gate_lvl)) begin
            w_mag = '0;
        end
        w_sq_full = (2*SAMPLE_BITS)'(w_mag) * (2*SAMPLE_BITS)'(w_mag);
        w_sq      = w_sq_full[SQ_W-1:0];
    end

    // lane update
    always_comb begin
        n_sum  = r_sum;
        n_len  = r_len;
        n_open = r_open;
        n_next = r_next;
        if (r_phase == '0 && !r_open[r_next]) begin
            n_open[r_next] = 1'b1;
            n_sum[r_next]  = '0;
            n_len[r_next]  = '0;
            n_next         = slot_inc(r_next);
        end
        for (int i = 0; i < OPEN_FRAMES; i++) begin
            if (n_open[i] && n_len[i] < w_frm) begin
                n_sum[i] = n_sum[i] + SUM_W'(w_sq);
                n_len[i] = n_len[i] + 1'b1;
            end
        end
        w_ph1   = (CFG_SIZE_W+1)'(r_phase) + 1'b1;
        n_phase = (w_ph1 >= (CFG_SIZE_W+1)'(w_hop)) ? '0 : w_ph1[CFG_SIZE_W-1:0];
        w_close = n_open[r_oldest] && (i_in.clip_end || n_len[r_oldest] >= w_frm);
    end

    assign o_push          = w_acc && (i_in.clip_end || w_close);
    assign o_job.has_frame = w_close;
    assign o_job.is_end    = i_in.clip_end;
    assign o_job.sum       = JOB_SUM_W'(n_sum[r_oldest]);
    assign o_job.len       = n_len[r_oldest];

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_sum <= n_sum;
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= '0;
            r_oldest <= '0;
            r_next   <= '0;
            r_phase  <= '0;
        end else if (w_acc) begin
            if (i_in.clip_end) begin
                r_open   <= '0;
                r_oldest <= '0;
                r_next   <= '0;
                r_phase  <= '0;
            end else begin
                r_next  <= n_next;
                r_phase <= n_phase;
                if (w_close) begin
                    r_open           <= n_open & ~(OPEN_FRAMES'(1) << r_oldest);
                    r_oldest         <= slot_inc(r_oldest);
                end else begin
                    r_open <= n_open;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/fre_back.sv =====
`default_nettype none

// Per frame job: mean square divide, root, Welford update, optional result; variance at clip end.
module fre_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_empty,
    input  fre_pkg::t_job  i_job,
    output logic           o_pop,
    input  wire logic      i_emit,
    fre_out_if.source      o_out
);
    import fre_pkg::*;

    t_back_st r_st;
    t_back_st n_st;

    t_job                  r_job;
    logic [DIV_NUM_W-1:0]  r_rad;
    logic [33:0]           r_srem;
    logic [31:0]           r_root;
    logic [SQRT_CNT_W-1:0] r_scnt;
    logic [CNT_W-1:0]      r_count;
    logic [MEAN_W-1:0]     r_mean;
    logic [ACC_W-1:0]      r_acc;
    logic [MEAN_W-1:0]     r_d;
    logic                  r_xge;
    logic [ACC_W-1:0]      r_prod;
    logic                  r_kind;
    logic [RES_W-1:0]      r_val;
    logic                  r_eor;

    logic                  w_div_start;
    logic                  w_div_done;
    logic [DIV_NUM_W-1:0]  w_num;
    logic [DIV_DEN_W-1:0]  w_den;
    logic [DIV_NUM_W-1:0]  w_quo;

    logic [33:0]           w_st;
    logic [33:0]           w_strial;
    logic [RMS_W-1:0]      w_rms;
    logic [MEAN_W-1:0]     w_x;
    logic [CNT_W-1:0]      w_cnt_inc;
    logic                  w_xge;
    logic [MEAN_W-1:0]     w_d;
    logic [MEAN_W-1:0]     w_step;
    logic [ACC_W:0]        w_sum;

    fre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Welford operands
    always_comb begin
        w_rms     = (r_root > RMS_MAX) ? RMS_MAX[RMS_W-1:0] : r_root[RMS_W-1:0];
        w_x       = {w_rms, 8'h00};
        w_cnt_inc = (r_count == '1) ? r_count : r_count + 1'b1;
        w_xge     = (w_x >= r_mean);
        w_d       = w_xge ? w_x - r_mean : r_mean - w_x;
        w_step    = w_quo[MEAN_W-1:0];
        w_sum     = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_prod >> 16);
        w_st      = {r_srem[31:0], r_rad[DIV_NUM_W-1 -: 2]};
        w_strial  = {r_root, 2'b01};
    end

    always_comb begin
        case (r_st)
            BK_Q_GO: begin
                w_num = {r_job.sum[DIV_NUM_W-17:0], 16'h0000};
                w_den = DIV_DEN_W'(r_job.len);
            end
            BK_W_GO: begin
                w_num = DIV_NUM_W'(w_d);
                w_den = w_cnt_inc;
            end
            default: begin
                w_num = r_acc;
                w_den = r_count;
            end
        endcase
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BK_IDLE:   if (!i_empty) n_st = i_job.has_frame ? BK_Q_GO : BK_V_GO;
            BK_Q_GO:   n_st = BK_Q_WAIT;
            BK_Q_WAIT: if (w_div_done) n_st = BK_SQ_GO;
            BK_SQ_GO:  n_st = BK_SQ_RUN;
            BK_SQ_RUN: if (r_scnt == SQRT_CNT_W'(SQRT_STEPS - 1)) n_st = BK_W_GO;
            BK_W_GO:   n_st = BK_W_WAIT;
            BK_W_WAIT: if (w_div_done) n_st = BK_MUL;
            BK_MUL:    n_st = BK_ACC;
            BK_ACC: begin
                if (i_emit) begin
                    n_st = BK_EMIT_F;
                end else begin
                    n_st = r_job.is_end ? BK_V_GO : BK_IDLE;
                end
            end
            BK_EMIT_F: if (o_out.ready) n_st = r_job.is_end ? BK_V_GO : BK_IDLE;
            BK_V_GO:   n_st = BK_V_WAIT;
            BK_V_WAIT: if (w_div_done) n_st = BK_EMIT_V;
            BK_EMIT_V: if (o_out.ready) n_st = BK_IDLE;
            default:   n_st = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop       = (r_st == BK_IDLE) && !i_empty;
        w_div_start = (r_st == BK_Q_GO) || (r_st == BK_W_GO) || (r_st == BK_V_GO);
        o_out.valid = (r_st == BK_EMIT_F) || (r_st == BK_EMIT_V);
    end

    assign o_out.kind         = r_kind;
    assign o_out.result_value = r_val;
    assign o_out.frame_count  = r_count;
    assign o_out.end_of_run   = r_eor;

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            BK_IDLE: begin
                r_job <= i_job;
            end
            BK_SQ_GO: begin
                r_rad  <= w_quo;
                r_srem <= '0;
                r_root <= '0;
                r_scnt <= '0;
            end
            BK_SQ_RUN: begin
                r_rad  <= {r_rad[DIV_NUM_W-3:0], 2'b00};
                r_scnt <= r_scnt + 1'b1;
                if (w_st >= w_strial) begin
                    r_srem <= w_st - w_strial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_srem <= w_st;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            BK_W_GO: begin
                r_d    <= w_d;
                r_xge  <= w_xge;
                r_val  <= RES_W'(w_rms);
                r_kind <= KIND_FRAME;
                r_eor  <= !r_job.is_end;
            end
            BK_MUL: begin
                r_prod <= ACC_W'(r_d) * ACC_W'(r_d - w_step);
            end
            BK_V_WAIT: begin
                r_kind <= KIND_VAR;
                r_eor  <= 1'b1;
                if (r_count == '0) begin
                    r_val <= '0;
                end else if (w_quo[DIV_NUM_W-1:RES_W] != '0) begin
                    r_val <= '1;
                end else begin
                    r_val <= w_quo[RES_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // clip statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= BK_IDLE;
            r_count <= '0;
            r_mean  <= '0;
            r_acc   <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                BK_W_GO: begin
                    r_count <= w_cnt_inc;
                end
                BK_MUL: begin
                    r_mean <= r_xge ? r_mean + w_step : r_mean - w_step;
                end
                BK_ACC: begin
                    r_acc <= w_sum[ACC_W] ? '1 : w_sum[ACC_W-1:0];
                end
                BK_EMIT_V: begin
                    if (o_out.ready) begin
                        r_count <= '0;
                        r_mean  <= '0;
                        r_acc   <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/framed_rms_variance_top.sv =====
`default_nettype none

// Channel   Dir  Fields                                          Taken when
// i_in      in   sample, clip_end                                valid & ready
// o_out     out  kind, result_value, frame_count, end_of_run     valid & ready
// i_cfg_*   in   i_cfg_idx, i_cfg_data                           i_cfg_we
//
// A sample is taken whenever the job queue (4 deep) has room.
// Each closed frame costs the back end a divide for the mean square, 32 root
// steps, a Welford divide, a multiply and an add.
// Clip end adds one more divide for the variance.
// Reset is synchronous; there is no clearing pass. A stalled o_out holds the
// back end, which then backs up the queue and finally drops i_in.ready.
module framed_rms_variance_top #(
    parameter int OPEN_FRAMES = 8,
    parameter int MAX_FRAME   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    fre_in_if.sink                                 i_in,
    fre_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [fre_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [fre_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fre_pkg::*;

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_pop_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_lvl    <= NOISE_RST;
            r_cfg.frm_len     <= FRAME_RST;
            r_cfg.hop_len     <= HOP_RST;
            r_cfg.emit_frames <= EMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NOISE_FLOOR: r_cfg.gate_lvl    <= i_cfg_data;
                CFG_FRAME_SIZE:  r_cfg.frm_len     <= i_cfg_data[CFG_SIZE_W-1:0];
                CFG_HOP_SIZE:    r_cfg.hop_len     <= i_cfg_data[CFG_SIZE_W-1:0];
                CFG_EMIT_FRAMES: r_cfg.emit_frames <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // front: frame lanes and close detection
    fre_front #(
        .OPEN_FRAMES (OPEN_FRAMES),
        .MAX_FRAME   (MAX_FRAME),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    // job queue decouples sample intake from the slow math
    fre_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_empty (w_empty)
    );

    // back: RMS, Welford, variance
    fre_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_pop_job),
        .o_pop   (w_pop),
        .i_emit  (r_cfg.emit_frames),
        .o_out   (o_out)
    );

    // clip end always produces a job
    a_end_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.clip_end) |-> w_push)
        else $error("clip end not queued");

    // a variance item closes the run
    a_var_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_VAR) |-> o_out.end_of_run)
        else $error("variance without end_of_run");

    // a frame item has been counted
    a_frame_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_FRAME) |-> (o_out.frame_count != '0))
        else $error("frame item with zero count");

endmodule

`default_nettype wire

// ===== bench/fre_checker.sv =====
`timescale 1ns / 1ps

module fre_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    fre_in_if                                    mon_in,
    fre_out_if                                   mon_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [fre_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fre_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                   o_errors,
    output int                                   o_pending
);
    import fre_pkg::*;

    localparam int SLOTS = 8;
    localparam int MAXF  = 4096;

    typedef struct packed {
        logic        kind;
        logic [47:0] value;
        logic [31:0] count;
        logic        last;
    } t_exp_res;

    t_exp_res expected_q[$];

    // shadow registers
    logic [15:0] floor_r;
    logic [12:0] frame_r, hop_r;
    logic        emit_r;

    // clip state
    logic [63:0] sums[SLOTS];
    logic [12:0] lens[SLOTS];
    logic        open_f[SLOTS];
    int          oldest, next_s;
    int          phase;
    logic [31:0] n_rms;
    logic [63:0] mean, sq_acc;

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic clear_clip();
        for (int i = 0; i < SLOTS; i++) begin
            sums[i] = 0;
            lens[i] = 0;
            open_f[i] = 0;
        end
        oldest = 0;
        next_s = 0;
        phase = 0;
        n_rms = 0;
        mean = 0;
        sq_acc = 0;
    endtask

    task automatic queue_result(logic k, logic [47:0] v, logic [31:0] c, logic l);
        t_exp_res item;
        item.kind  = k;
        item.value = v;
        item.count = c;
        item.last  = l;
        expected_q.insert(expected_q.size(), item);
    endtask

    // close oldest frame, fold into Welford stats, return RMS
    task automatic close_frame(output logic [63:0] rms);
        logic [63:0] len, sum, q, x, d, stp, term;
        logic [64:0] tot;
        len = (lens[oldest] == 0) ? 64'd1 : 64'(lens[oldest]);
        sum = sums[oldest];
        q = ((sum / len) << 16) + (((sum % len) << 16) / len);
        rms = root64(q);
        if (rms > 64'(RMS_MAX)) rms = 64'(RMS_MAX);
        open_f[oldest] = 0;
        sums[oldest] = 0;
        lens[oldest] = 0;
        oldest = (oldest + 1) % SLOTS;
        if (n_rms != 32'hFFFF_FFFF) n_rms = n_rms + 1;
        x = rms << 8;
        if (x >= mean) begin
            d = x - mean;
            stp = d / 64'(n_rms);
            mean = mean + stp;
        end else begin
            d = mean - x;
            stp = d / 64'(n_rms);
            mean = mean - stp;
        end
        term = (d * (d - stp)) >> 16;
        tot = {1'b0, sq_acc} + {1'b0, term};
        sq_acc = tot[64] ? 64'hFFFF_FFFF_FFFF_FFFF : tot[63:0];
    endtask

    task automatic predict_sample(logic [15:0] raw, logic is_end);
        logic [16:0] mag;
        logic [63:0] sq, rms, var_v;
        int          hop, frm, cap;
        hop = (hop_r == 0) ? 1 : int'(hop_r);
        if (hop > MAXF) hop = MAXF;
        frm = (frame_r == 0) ? 1 : int'(frame_r);
        cap = hop * SLOTS;
        if (frm > MAXF) frm = MAXF;
        if (frm > cap) frm = cap;

        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        if (mag < {1'b0, floor_r}) mag = 0;
        sq = 64'(mag) * 64'(mag);

        if (phase == 0 && !open_f[next_s]) begin
            open_f[next_s] = 1;
            sums[next_s] = 0;
            lens[next_s] = 0;
            next_s = (next_s + 1) % SLOTS;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (open_f[i] && int'(lens[i]) < frm) begin
                sums[i] = sums[i] + sq;
                lens[i] = lens[i] + 1;
            end
        end
        phase = phase + 1;
        if (phase >= hop) phase = 0;

        if (is_end) begin
            if (open_f[oldest]) begin
                close_frame(rms);
                if (emit_r) queue_result(KIND_FRAME, rms[47:0], n_rms, 1'b0);
            end
            var_v = (n_rms == 0) ? 64'd0 : sq_acc / 64'(n_rms);
            if (var_v > 64'hFFFF_FFFF_FFFF) var_v = 64'hFFFF_FFFF_FFFF;
            queue_result(KIND_VAR, var_v[47:0], n_rms, 1'b1);
            clear_clip();
        end else if (open_f[oldest] && int'(lens[oldest]) >= frm) begin
            close_frame(rms);
            if (emit_r) queue_result(KIND_FRAME, rms[47:0], n_rms, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        t_exp_res want;
        if (!i_rst_n) begin
            floor_r = NOISE_RST;
            frame_r = FRAME_RST;
            hop_r = HOP_RST;
            emit_r = EMIT_RST;
            clear_clip();
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NOISE_FLOOR: floor_r = i_cfg_data;
                    CFG_FRAME_SIZE:  frame_r = i_cfg_data[12:0];
                    CFG_HOP_SIZE:    hop_r = i_cfg_data[12:0];
                    CFG_EMIT_FRAMES: emit_r = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (mon_out.valid && mon_out.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result item with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.kind !== mon_out.kind) begin
                        $error("kind: expected %0d actual %0d", want.kind, mon_out.kind);
                        o_errors <= o_errors + 1;
                    end else if (want.value !== mon_out.result_value) begin
                        $error("result_value: expected %0d actual %0d",
                               want.value, mon_out.result_value);
                        o_errors <= o_errors + 1;
                    end else if (want.count !== mon_out.frame_count) begin
                        $error("frame_count: expected %0d actual %0d",
                               want.count, mon_out.frame_count);
                        o_errors <= o_errors + 1;
                    end else if (want.last !== mon_out.end_of_run) begin
                        $error("end_of_run: expected %0d actual %0d",
                               want.last, mon_out.end_of_run);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (mon_in.valid && mon_in.ready)
                predict_sample(mon_in.sample, mon_in.clip_end);
        end
        o_pending <= expected_q.size();
    end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fre_pkg::*;

    localparam int SETTLE = 2000;    // covers a full queue of silent frame jobs
    localparam int WD_LIMIT = 40000; // cycles with no item moving

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int n_errors, n_pending;
    int send_idle, recv_stall; // percent
    int quiet_cycles;
    int n_sent;

    fre_in_if  #(.SAMPLE_BITS(16)) in_ch ();
    fre_out_if out_ch ();

    framed_rms_variance_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    fre_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .mon_in(in_ch), .mon_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(n_errors), .o_pending(n_pending)
    );

    always #6 i_clk = ~i_clk;

    // result side back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog: any cycle where no item moves counts toward the limit
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // idle mode rotates every 40 items: none, sender, receiver, both
    task automatic pick_idle_mode();
        case ((n_sent / 40) % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 78; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 78; end
            default: begin send_idle = 21; recv_stall = 21; end
        endcase
    endtask

    task automatic send_item(logic [15:0] smp, logic last);
        pick_idle_mode();
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample <= smp;
        in_ch.clip_end <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    // waits for the expected results to drain; pause covers frames still in flight
    task automatic set_regs(logic [15:0] nf, logic [12:0] fs, logic [12:0] hs, logic em);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        for (int r = 0; r < 4; r++) begin
            i_cfg_we <= 1'b1;
            case (r)
                0: begin i_cfg_idx <= CFG_NOISE_FLOOR; i_cfg_data <= nf; end
                1: begin i_cfg_idx <= CFG_FRAME_SIZE;  i_cfg_data <= 16'(fs); end
                2: begin i_cfg_idx <= CFG_HOP_SIZE;    i_cfg_data <= 16'(hs); end
                default: begin i_cfg_idx <= CFG_EMIT_FRAMES; i_cfg_data <= 16'(em); end
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample(logic [15:0] nf);
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return nf + 16'($urandom_range(2)) - 16'd1; // around the floor
            3: return 16'($signed(-$signed({1'b0, nf})));
            4: return 16'($urandom_range(255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    logic [15:0] nf_t;
    logic [12:0] fs_t, hs_t;
    logic        em_t;
    int          end_odds;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.clip_end = 1'b0;
        out_ch.ready = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        n_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // overlapping 2-sample frames every sample; floor edges, full scale
        set_regs(16'd100, 13'd2, 13'd1, 1'b1);
        send_item(16'd99, 1'b0);           // just under floor -> silence
        send_item(-16'sd100, 1'b0);        // exactly at floor
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b0);         // most negative
        send_item(16'd0, 1'b0);
        send_item(16'h8000, 1'b1);         // truncated last frame + variance
        send_item(16'h7FFF, 1'b1);         // one-sample clip
        // frame closes before end, next not yet open: variance only
        set_regs(16'd0, 13'd1, 13'd4, 1'b1);
        send_item(16'd5, 1'b0);
        send_item(16'd6, 1'b1);
        // zero sizes act as one, frame values suppressed
        set_regs(16'd32768, 13'd0, 13'd0, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'hFFFF, 1'b1);
        // oversized sizes clamp to the max frame
        set_regs(16'd0, 13'd8191, 13'd8191, 1'b1);
        send_item(16'h1234, 1'b0);
        send_item(16'hEDCB, 1'b1);

        // random phases; clips may straddle a phase boundary so a later,
        // smaller hop can run out of free slots or shrink an open frame
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin nf_t = 0;     fs_t = 8;    hs_t = 4;  em_t = 1; end
                1: begin nf_t = 16'd32768; fs_t = 1; hs_t = 1; em_t = 1; end
                2: begin nf_t = 200;   fs_t = 16;   hs_t = 2;  em_t = 0; end
                3: begin nf_t = 16'($urandom); fs_t = 64; hs_t = 8; em_t = 1; end
                4: begin nf_t = 0;     fs_t = 100;  hs_t = 3;  em_t = 1; end // clamped
                5: begin nf_t = 300;   fs_t = 4096; hs_t = 1;  em_t = 1; end // clamped
                6: begin nf_t = 0;     fs_t = 8191; hs_t = 8191; em_t = 1; end
                7: begin nf_t = 16'($urandom_range(4000)); fs_t = 13'($urandom_range(1, 40));
                          hs_t = 13'($urandom_range(1, 12)); em_t = 1'($urandom); end
                8: begin nf_t = 16'hFFFF; fs_t = 3; hs_t = 5; em_t = 1; end
                default: begin nf_t = 0; fs_t = 24; hs_t = 2; em_t = 1; end
            endcase
            set_regs(nf_t, fs_t, hs_t, em_t);
            end_odds = (ph == 6) ? 8 : (em_t ? 40 : 6);
            for (int k = 0; k < 120; k++)
                send_item(rand_sample(nf_t), ($urandom_range(end_odds - 1) == 0));
        end
        // close any clip left open so its variance is checked
        send_item(16'($urandom), 1'b1);
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
